FILE: hw/rtl/frs_pkg.sv
package frs_pkg;

	localparam int ID_W          = 8;
	localparam int PAYLOAD_W     = 40;
	localparam int COUNT_W       = 3;
	localparam int KEY_WIDTH     = 8;
	localparam int PAYLOAD_BYTES = 5;
	localparam int DEPTH_DEF     = 32;
	localparam int BYTE_SLOTS    = PAYLOAD_W / 8;

	// low KEY_WIDTH bits of the id take part in ordering
	localparam logic [ID_W-1:0] KEY_MASK =
		(KEY_WIDTH >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << KEY_WIDTH) - 1);

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [PAYLOAD_W-1:0] payload;
		logic [COUNT_W-1:0]   count;
	} frame_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	function automatic logic [ID_W-1:0] key_of(input logic [ID_W-1:0] id);
		return id & KEY_MASK;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
		return (c > COUNT_W'(PAYLOAD_BYTES)) ? COUNT_W'(PAYLOAD_BYTES) : c;
	endfunction

	// zero every byte at or above the byte count
	function automatic logic [PAYLOAD_W-1:0] clean_payload(input logic [PAYLOAD_W-1:0] p,
			input logic [COUNT_W-1:0] c);
		logic [PAYLOAD_W-1:0] r;
		r = '0;
		for (int b = 0; b < BYTE_SLOTS; b++) begin
			if (COUNT_W'(b) < c) begin
				r[b*8 +: 8] = p[b*8 +: 8];
			end
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/frs_store.sv
module frs_store #(
	parameter int DEPTH = frs_pkg::DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  frs_pkg::frame_t wr_data,
	input  logic [AW-1:0]  rd_addr,
	output frs_pkg::frame_t rd_data
);
	import frs_pkg::*;

	frame_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: hw/rtl/frame_reorder_insertion_sort.sv
// Channel  Direction  Handshake            Payload
// in       to block   in_valid / in_stall  frame_id, payload, byte_count, last_in
// out      from block out_valid / out_stall out_id, out_payload, out_count, last_out, overflow
//
// Each frame is inserted into a sorted frame memory (one write, one read port).
// Insertion walks back past the stored frames with a larger key, shifting each up one slot;
// a frame into an empty store is written directly, and one into a full store is dropped.
// After the last frame, each result is read and then loaded into the output register.
// Reset clears the fill level, drop flag and state; the memory itself is not cleared.
// out_stall holds the output register; the input is stalled while inserting or emitting.
module frame_reorder_insertion_sort #(
	parameter int DEPTH = frs_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [frs_pkg::ID_W-1:0]      frame_id,
	input  logic [frs_pkg::PAYLOAD_W-1:0] payload,
	input  logic [frs_pkg::COUNT_W-1:0]   byte_count,
	input  logic                          last_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [frs_pkg::ID_W-1:0]      out_id,
	output logic [frs_pkg::PAYLOAD_W-1:0] out_payload,
	output logic [frs_pkg::COUNT_W-1:0]   out_count,
	output logic                          last_out,
	output logic                          overflow
);
	import frs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [AW-1:0] j_q, j_d;
	logic [AW-1:0] i_q, i_d;
	logic          dropped_q, dropped_d;
	logic          last_q, last_d;
	frame_t        new_q, new_d;
	frame_t        in_frame;
	logic [COUNT_W-1:0] cnt_sat;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	frame_t        wr_data;
	logic [AW-1:0] rd_addr;
	frame_t        rd_data;

	logic          full;
	logic          rd_key_gt;
	logic          emit_last;
	logic          can_load;
	logic          load_out;
	logic          out_valid_q;
	frame_t        out_frame_q;
	logic          last_out_q;
	logic          overflow_q;

	frs_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cnt_sat   = sat_count(byte_count);
	assign in_frame  = '{id: frame_id, payload: clean_payload(payload, cnt_sat), count: cnt_sat};
	assign full      = (fill_q == CW'(DEPTH));
	assign rd_key_gt = key_of(rd_data.id) > key_of(new_q.id);
	assign emit_last = ((CW'(i_q) + CW'(1)) == fill_q);
	assign can_load  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);

	// Reads run one entry ahead of the write, and each phase waits for the
	// previous one to retire, so a read never meets a pending write to its entry.
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		j_d       = j_q;
		i_d       = i_q;
		dropped_d = dropped_q;
		last_d    = last_q;
		new_d     = new_q;
		wr_en     = 1'b0;
		wr_addr   = j_q;
		wr_data   = new_q;
		rd_addr   = i_q;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = AW'(fill_q - CW'(1));
				if (in_valid) begin
					new_d  = in_frame;
					last_d = last_in;
					j_d    = AW'(fill_q);
					i_d    = '0;
					if (full) begin
						// drop the frame; a last frame still flushes the batch
						dropped_d = 1'b1;
						state_d   = last_in ? ST_EMIT_RD : ST_IDLE;
					end else if (fill_q == '0) begin
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = in_frame;
						fill_d  = CW'(1);
						state_d = last_in ? ST_EMIT_RD : ST_IDLE;
					end else begin
						state_d = ST_INS_CMP;
					end
				end
			end
			ST_INS_CMP: begin
				rd_addr = j_q - AW'(2);
				wr_en   = 1'b1;
				wr_addr = j_q;
				if (rd_key_gt) begin
					// shift the larger entry up one slot
					wr_data = rd_data;
					j_d     = j_q - AW'(1);
					if (j_q == AW'(1)) begin
						state_d = ST_INS_PUT;
					end
				end else begin
					wr_data = new_q;
					fill_d  = fill_q + CW'(1);
					state_d = last_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = new_q;
				fill_d  = fill_q + CW'(1);
				state_d = last_q ? ST_EMIT_RD : ST_IDLE;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (can_load) begin
					load_out = 1'b1;
					if (emit_last) begin
						fill_d    = '0;
						dropped_d = 1'b0;
						state_d   = ST_IDLE;
					end else begin
						i_d     = i_q + AW'(1);
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			j_q       <= '0;
			i_q       <= '0;
			dropped_q <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q    <= fill_d;
			j_q       <= j_d;
			i_q       <= i_d;
			dropped_q <= dropped_d;
			last_q    <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		new_q <= new_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_frame_q <= rd_data;
			last_out_q  <= emit_last;
			overflow_q  <= dropped_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_id      = out_frame_q.id;
	assign out_payload = out_frame_q.payload;
	assign out_count   = out_frame_q.count;
	assign last_out    = last_out_q;
	assign overflow    = overflow_q;

endmodule

FILE: hw/rtl/frs_checker.sv
module frs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          last_in,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [frs_pkg::ID_W-1:0]      out_id,
	input logic [frs_pkg::PAYLOAD_W-1:0] out_payload,
	input logic [frs_pkg::COUNT_W-1:0]   out_count,
	input logic                          last_out,
	input logic                          overflow
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_id) && $stable(out_payload)
			&& $stable(out_count) && $stable(last_out) && $stable(overflow))
		else $error("stalled result changed");

	// a batch still draining keeps the input stalled
	a_drain_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_out |-> in_stall)
		else $error("input open while batch still draining");

	// overflow is one value across a batch
	a_ovf_batch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_out |=> $stable(overflow))
		else $error("overflow changed inside a batch");

	// a last transaction always starts the flush
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_in |=> in_stall)
		else $error("last frame did not start the flush");

endmodule

bind frame_reorder_insertion_sort frs_checker u_frs_checker (.*);

FILE: tb/frame_reorder_insertion_sort_chk.sv
module frame_reorder_insertion_sort_chk #(
	parameter int DEPTH = frs_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [frs_pkg::ID_W-1:0]      frame_id,
	input  logic [frs_pkg::PAYLOAD_W-1:0] payload,
	input  logic [frs_pkg::COUNT_W-1:0]   byte_count,
	input  logic                          last_in,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [frs_pkg::ID_W-1:0]      out_id,
	input  logic [frs_pkg::PAYLOAD_W-1:0] out_payload,
	input  logic [frs_pkg::COUNT_W-1:0]   out_count,
	input  logic                          last_out,
	input  logic                          overflow,
	output int                            mismatches,
	output int                            pending_results,
	output int                            results_checked
);
	import frs_pkg::*;

	typedef struct packed {
		frame_t frame;
		logic   last;
		logic   dropped;
	} sorted_frame_t;

	frame_t        batch_frames[$];
	logic          batch_dropped;
	sorted_frame_t sorted_q[$];
	int            lines_printed;

	task automatic report_mismatch(input string msg);
		if (lines_printed < 40) begin
			$display("MISMATCH @%0t: %s", $time, msg);
		end
		lines_printed++;
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		frame_t               f;
		frame_t               ordered[$];
		logic [COUNT_W-1:0]   kept;
		logic [PAYLOAD_W-1:0] keep_mask;
		sorted_frame_t        want;
		int                   pos;
		if (!arst_n) begin
			batch_frames.delete();
			sorted_q.delete();
			batch_dropped = 1'b0;
			mismatches = 0;
			results_checked = 0;
			lines_printed = 0;
			pending_results <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				kept = (byte_count > COUNT_W'(PAYLOAD_BYTES)) ? COUNT_W'(PAYLOAD_BYTES) : byte_count;
				keep_mask = ~({PAYLOAD_W{1'b1}} << (8 * kept));
				if (batch_frames.size() < DEPTH) begin
					f.id = frame_id;
					f.payload = payload & keep_mask;
					f.count = kept;
					batch_frames.push_back(f);
				end else begin
					batch_dropped = 1'b1;
				end
				if (last_in) begin
					// stable insertion: walk back only past strictly larger keys
					ordered.delete();
					foreach (batch_frames[i]) begin
						pos = ordered.size();
						while (pos > 0 && (ordered[pos-1].id & KEY_MASK) >
								(batch_frames[i].id & KEY_MASK)) begin
							pos--;
						end
						ordered.insert(pos, batch_frames[i]);
					end
					foreach (ordered[i]) begin
						want.frame = ordered[i];
						want.last = (i == ordered.size() - 1);
						want.dropped = batch_dropped;
						sorted_q.push_back(want);
					end
					batch_frames.delete();
					batch_dropped = 1'b0;
				end
			end
			if (out_valid && !out_stall) begin
				if (sorted_q.size() == 0) begin
					report_mismatch($sformatf("result with id %h while no frame is pending",
						out_id));
				end else begin
					want = sorted_q.pop_front();
					if (out_id !== want.frame.id) begin
						report_mismatch($sformatf("result %0d out_id: expected %h got %h",
							results_checked, want.frame.id, out_id));
					end
					if (out_payload !== want.frame.payload) begin
						report_mismatch($sformatf("result %0d out_payload: expected %h got %h",
							results_checked, want.frame.payload, out_payload));
					end
					if (out_count !== want.frame.count) begin
						report_mismatch($sformatf("result %0d out_count: expected %0d got %0d",
							results_checked, want.frame.count, out_count));
					end
					if (last_out !== want.last) begin
						report_mismatch($sformatf("result %0d last_out: expected %b got %b",
							results_checked, want.last, last_out));
					end
					if (overflow !== want.dropped) begin
						report_mismatch($sformatf("result %0d overflow: expected %b got %b",
							results_checked, want.dropped, overflow));
					end
					results_checked++;
				end
			end
			pending_results <= sorted_q.size();
		end
	end

endmodule

FILE: tb/frame_reorder_insertion_sort_tb.sv
module frame_reorder_insertion_sort_tb;
	import frs_pkg::*;

	localparam int DEPTH         = DEPTH_DEF;
	localparam int STALL_LIMIT   = 5000;
	localparam int LONG_HOLD     = 600;
	localparam int SETTLE_CYCLES = 100;

	typedef enum {IDS_RANDOM, IDS_FALLING} id_order_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [ID_W-1:0]      frame_id;
	logic [PAYLOAD_W-1:0] payload;
	logic [COUNT_W-1:0]   byte_count;
	logic                 last_in;
	logic                 out_valid;
	logic                 out_stall;
	logic [ID_W-1:0]      out_id;
	logic [PAYLOAD_W-1:0] out_payload;
	logic [COUNT_W-1:0]   out_count;
	logic                 last_out;
	logic                 overflow;

	int mismatches;
	int pending_results;
	int results_checked;
	int sender_idle_pct;
	int receiver_idle_pct;
	int hold_requests;
	int frames_sent;
	int batches_sent;
	int overflow_batches;

	frame_reorder_insertion_sort #(.DEPTH(DEPTH)) DUT (.*);

	frame_reorder_insertion_sort_chk #(.DEPTH(DEPTH)) sort_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stall, or a long hold-off on request
	initial begin : receiver
		int hold_left;
		int holds_seen;
		out_stall = 1'b0;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left = LONG_HOLD;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < receiver_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [PAYLOAD_W-1:0] rand_payload();
		return PAYLOAD_W'({$urandom(), $urandom()});
	endfunction

	task automatic send_frame(input logic [ID_W-1:0] id, input logic [PAYLOAD_W-1:0] data,
			input logic [COUNT_W-1:0] cnt, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_id <= id;
		payload <= data;
		byte_count <= cnt;
		last_in <= last;
		do @(posedge clk); while (in_stall);
		frames_sent++;
		if (last) begin
			batches_sent++;
		end
	endtask

	task automatic send_batch(input int n, input id_order_t order);
		logic [ID_W-1:0]    id;
		logic [COUNT_W-1:0] cnt;
		if (n > DEPTH) begin
			overflow_batches++;
		end
		for (int i = 0; i < n; i++) begin
			if (order == IDS_FALLING) begin
				id = ID_W'(250 - 7 * i);
			end else if ($urandom_range(3) == 0) begin
				// crowd a few ids so equal keys show up often
				id = ID_W'($urandom_range(3));
			end else begin
				id = ID_W'($urandom_range(255));
			end
			if ($urandom_range(4) == 0) begin
				cnt = COUNT_W'($urandom_range(7));
			end else begin
				cnt = COUNT_W'($urandom_range(5, 1));
			end
			send_frame(id, rand_payload(), cnt, i == n - 1);
		end
	endtask

	// hold the sender until the last sorted frame has left
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	task automatic run_phase(input int snd_pct, input int rcv_pct, input int lead_size,
			input id_order_t lead_order, input int items);
		int first;
		int n;
		int r;
		sender_idle_pct = snd_pct;
		receiver_idle_pct = rcv_pct;
		send_batch(lead_size, lead_order);
		first = frames_sent;
		while (frames_sent - first < items) begin
			r = $urandom_range(99);
			if (r < 70) begin
				n = $urandom_range(6, 1);
			end else if (r < 95) begin
				n = $urandom_range(20, 7);
			end else begin
				n = $urandom_range(DEPTH, 21);
			end
			send_batch(n, IDS_RANDOM);
		end
		wait_drained();
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		frame_id = '0;
		payload = '0;
		byte_count = '0;
		last_in = 1'b0;
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_requests = 0;
		frames_sent = 0;
		batches_sent = 0;
		overflow_batches = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone frame: top id, full payload, count above the payload width
		send_frame(8'hFF, '1, 3'd7, 1'b1);
		// equal ids keep arrival order; every byte count from zero to seven
		send_frame(8'd5, '1, 3'd0, 1'b0);
		send_frame(8'd5, rand_payload(), 3'd1, 1'b0);
		send_frame(8'd0, '1, 3'd2, 1'b0);
		send_frame(8'hFF, rand_payload(), 3'd3, 1'b0);
		send_frame(8'd5, '1, 3'd4, 1'b0);
		send_frame(8'd0, rand_payload(), 3'd5, 1'b0);
		send_frame(8'hFF, '1, 3'd6, 1'b0);
		send_frame(8'h80, '0, 3'd7, 1'b0);
		send_frame(8'd5, 40'hA5_A5A5_A5A5, 3'd5, 1'b1);
		send_batch(10, IDS_FALLING);
		send_frame(8'd1, rand_payload(), 3'd5, 1'b0);
		send_frame(8'd2, '1, 3'd5, 1'b0);
		send_frame(8'd3, rand_payload(), 3'd1, 1'b1);
		wait_drained();

		// block the output while a batch sorts and the next one queues up
		hold_requests++;
		run_phase(10, 85, 12, IDS_FALLING, 50);
		run_phase(85, 10, DEPTH + 1, IDS_RANDOM, 40);
		send_batch(DEPTH, IDS_RANDOM);
		run_phase(0, 0, DEPTH + 4, IDS_FALLING, 40);

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sorted %0d batches from %0d frames (%0d past the store depth), %0d results compared.",
			batches_sent, frames_sent, overflow_batches, results_checked);
		$display("Idle mixes: sender-heavy, receiver-heavy and none, with a %0d-cycle output hold-off.",
			LONG_HOLD);
		if (mismatches == 0 && pending_results == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
